[rtl/lfc_pkg.sv]
package lfc_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int SPEED_W    = 12;
  localparam int OUT_W      = 13;
  localparam int TICK_W     = 16;
  localparam int FLIP_W     = 8;
  localparam int GAIN_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int MODE_W     = 3;
  // signed working width for base +- turn before the clamp
  localparam int WIDE_W     = 28;

  typedef enum logic [MODE_W-1:0] {
    MODE_BOTH   = 3'd0,
    MODE_LEFT   = 3'd1,
    MODE_RIGHT  = 3'd2,
    MODE_SEARCH = 3'd3,
    MODE_STOP   = 3'd4
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_THRESHOLD = 3'd0,
    REG_BASE_SPEED     = 3'd1,
    REG_TURN_SPEED     = 3'd2,
    REG_MAX_SPEED      = 3'd3,
    REG_LOST_TIMEOUT   = 3'd4,
    REG_DIFF_DEADBAND  = 3'd5,
    REG_STEER_GAIN     = 3'd6,
    REG_SEARCH_FLIP    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] line_threshold;
    logic [SPEED_W-1:0]  cruise_speed;
    logic [SPEED_W-1:0]  swerve_speed;
    logic [SPEED_W-1:0]  speed_limit;
    logic [TICK_W-1:0]   lost_timeout;
    logic [SAMPLE_W-1:0] diff_deadband;
    logic [GAIN_W-1:0]   steer_gain;
    logic [FLIP_W-1:0]   search_flip;
  } cfg_t;

  typedef struct packed {
    logic [TICK_W-1:0] lost_ticks;
    logic [FLIP_W-1:0] search_ticks;
    logic              spin_left;
  } track_t;

  localparam logic [SAMPLE_W-1:0] RST_LINE_THRESHOLD = 16'd112;
  localparam logic [SPEED_W-1:0]  RST_BASE_SPEED     = 12'd482;
  localparam logic [SPEED_W-1:0]  RST_TURN_SPEED     = 12'd241;
  localparam logic [SPEED_W-1:0]  RST_MAX_SPEED      = 12'd1608;
  localparam logic [TICK_W-1:0]   RST_LOST_TIMEOUT   = 16'd31;
  localparam logic [SAMPLE_W-1:0] RST_DIFF_DEADBAND  = 16'd8;
  localparam logic [GAIN_W-1:0]   RST_STEER_GAIN     = 16'd410;
  localparam logic [FLIP_W-1:0]   RST_SEARCH_FLIP    = 8'd50;

  localparam track_t RST_TRACK = '{lost_ticks: '0, search_ticks: '0, spin_left: 1'b1};

endpackage

[rtl/lfc_channels.sv]
interface lfc_in_if;
  logic                         valid;
  logic                         ready;
  logic [lfc_pkg::SAMPLE_W-1:0] left_sample;
  logic [lfc_pkg::SAMPLE_W-1:0] right_sample;
  modport source (output valid, left_sample, right_sample, input ready);
  modport sink   (input valid, left_sample, right_sample, output ready);
endinterface

interface lfc_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [lfc_pkg::OUT_W-1:0] left_speed;
  logic signed [lfc_pkg::OUT_W-1:0] right_speed;
  logic [lfc_pkg::MODE_W-1:0]       drive_mode;
  modport source (output valid, left_speed, right_speed, drive_mode, input ready);
  modport sink   (input valid, left_speed, right_speed, drive_mode, output ready);
endinterface

interface lfc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lfc_pkg::CFG_IDX_W-1:0]  index;
  logic [lfc_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/two_sensor_line_follower_control.sv]
// Pipeline: the sample word is held in the sample register, and its result is loaded
//   into the result register that drives speeds once that register may load.
// Throughput: one word per cycle unless speeds stalls; the sample and result registers form
//   a two-stage pipe, so a new word is taken while a finished result waits.
// Reset (rst, synchronous): pipe empty, config registers at their defaults,
//   lost/search counters zero, spin direction left.
module two_sensor_line_follower_control (
  input  logic      clk,
  input  logic      rst,
  lfc_in_if.sink    samples,
  lfc_out_if.source speeds,
  lfc_cfg_if.sink   cfg
);

  lfc_pkg::cfg_t   regs;
  lfc_pkg::track_t track;
  lfc_pkg::track_t track_next;

  // stage 1: registered sample word
  logic                         s1_valid;
  logic [lfc_pkg::SAMPLE_W-1:0] s1_left;
  logic [lfc_pkg::SAMPLE_W-1:0] s1_right;

  // stage 2: result register feeding the output channel
  logic                             out_valid;
  logic signed [lfc_pkg::OUT_W-1:0] out_left;
  logic signed [lfc_pkg::OUT_W-1:0] out_right;
  lfc_pkg::mode_t                   out_mode;

  logic signed [lfc_pkg::OUT_W-1:0] law_left;
  logic signed [lfc_pkg::OUT_W-1:0] law_right;
  lfc_pkg::mode_t                   law_mode;

  logic adv;   // result register may load
  logic fire;  // stage 1 word moves into the result register

  lfc_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  lfc_law u_law (
    .left_sample  (s1_left),
    .right_sample (s1_right),
    .cfg          (regs),
    .track        (track),
    .left_speed   (law_left),
    .right_speed  (law_right),
    .mode         (law_mode),
    .track_next   (track_next)
  );

  assign adv           = !out_valid || speeds.ready;
  assign fire          = s1_valid && adv;
  assign samples.ready = !s1_valid || adv;

  assign speeds.valid       = out_valid;
  assign speeds.left_speed  = out_left;
  assign speeds.right_speed = out_right;
  assign speeds.drive_mode  = out_mode;

  // control: valid bits and the tracking state. The lost/search state is
  // committed only when the word's result is captured, so it advances
  // exactly once per word and in order.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      track     <= lfc_pkg::RST_TRACK;
    end else begin
      if (samples.ready) begin
        s1_valid <= samples.valid;
      end
      if (adv) begin
        out_valid <= s1_valid;
      end
      if (fire) begin
        track <= track_next;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      s1_left  <= samples.left_sample;
      s1_right <= samples.right_sample;
    end
    if (fire) begin
      out_left  <= law_left;
      out_right <= law_right;
      out_mode  <= law_mode;
    end
  end

  // stop mode always drives both wheels to zero
  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_mode == lfc_pkg::MODE_STOP |-> out_left == '0 && out_right == '0)
    else $error("stop mode with nonzero wheel speed");

  // speeds held in the result register respect the clamp
  a_clamp: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_left <= $signed({1'b0, regs.speed_limit})
              && out_left >= -$signed({1'b0, regs.speed_limit})
              && out_right <= $signed({1'b0, regs.speed_limit})
              && out_right >= -$signed({1'b0, regs.speed_limit}))
    else $error("wheel speed outside clamp");

  // spin direction flips only together with a search counter restart
  a_flip: assert property (@(posedge clk) disable iff (rst)
    !$stable(track.spin_left) |-> track.search_ticks == '0)
    else $error("spin direction flipped without search counter clear");

  // input side stalls only when both stages are full and the output is blocked
  a_stall: assert property (@(posedge clk) disable iff (rst)
    !samples.ready |-> s1_valid && out_valid && !speeds.ready)
    else $error("input stalled with room in the pipe");

  // tracking state moves only when a word is captured
  a_track_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(track))
    else $error("tracking state changed without a word");

endmodule

[rtl/lfc_cfg_regs.sv]
module lfc_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  lfc_cfg_if.sink       cfg,
  output lfc_pkg::cfg_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.line_threshold <= lfc_pkg::RST_LINE_THRESHOLD;
      regs.cruise_speed   <= lfc_pkg::RST_BASE_SPEED;
      regs.swerve_speed   <= lfc_pkg::RST_TURN_SPEED;
      regs.speed_limit    <= lfc_pkg::RST_MAX_SPEED;
      regs.lost_timeout   <= lfc_pkg::RST_LOST_TIMEOUT;
      regs.diff_deadband  <= lfc_pkg::RST_DIFF_DEADBAND;
      regs.steer_gain     <= lfc_pkg::RST_STEER_GAIN;
      regs.search_flip    <= lfc_pkg::RST_SEARCH_FLIP;
    end else if (cfg.valid) begin
      case (lfc_pkg::reg_idx_t'(cfg.index))
        lfc_pkg::REG_LINE_THRESHOLD: regs.line_threshold <= cfg.data;
        lfc_pkg::REG_BASE_SPEED:     regs.cruise_speed <= cfg.data[lfc_pkg::SPEED_W-1:0];
        lfc_pkg::REG_TURN_SPEED:     regs.swerve_speed <= cfg.data[lfc_pkg::SPEED_W-1:0];
        lfc_pkg::REG_MAX_SPEED:      regs.speed_limit  <= cfg.data[lfc_pkg::SPEED_W-1:0];
        lfc_pkg::REG_LOST_TIMEOUT:   regs.lost_timeout  <= cfg.data;
        lfc_pkg::REG_DIFF_DEADBAND:  regs.diff_deadband <= cfg.data;
        lfc_pkg::REG_STEER_GAIN:     regs.steer_gain    <= cfg.data;
        lfc_pkg::REG_SEARCH_FLIP:    regs.search_flip <= cfg.data[lfc_pkg::FLIP_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/lfc_law.sv]
module lfc_law (
  input  logic [lfc_pkg::SAMPLE_W-1:0]    left_sample,
  input  logic [lfc_pkg::SAMPLE_W-1:0]    right_sample,
  input  lfc_pkg::cfg_t                   cfg,
  input  lfc_pkg::track_t                 track,
  output logic signed [lfc_pkg::OUT_W-1:0] left_speed,
  output logic signed [lfc_pkg::OUT_W-1:0] right_speed,
  output lfc_pkg::mode_t                  mode,
  output lfc_pkg::track_t                 track_next
);

  localparam int W    = lfc_pkg::WIDE_W;
  localparam int PADS = lfc_pkg::WIDE_W - lfc_pkg::SPEED_W;
  localparam int PW   = lfc_pkg::SAMPLE_W + lfc_pkg::GAIN_W;  // product width
  localparam int TW   = PW + 1 - 8;                           // rounded turn width

  function automatic logic signed [lfc_pkg::OUT_W-1:0] clamp(
    input logic signed [W-1:0]           v,
    input logic [lfc_pkg::SPEED_W-1:0]   m
  );
    logic signed [W-1:0] mw;
    logic signed [W-1:0] r;
    mw = $signed({{PADS{1'b0}}, m});
    if (v > mw)       r = mw;
    else if (v < -mw) r = -mw;
    else              r = v;
    return r[lfc_pkg::OUT_W-1:0];
  endfunction

  logic                               lon, ron;
  logic signed [lfc_pkg::SAMPLE_W:0]  diff;
  logic [lfc_pkg::SAMPLE_W-1:0]       mag;
  logic [PW-1:0]                      prod;
  logic [PW:0]                        rnd;
  logic [TW-1:0]                      tmag;
  logic signed [W-1:0]                turn, base_w, trn_w, lv, rv;
  logic [lfc_pkg::TICK_W-1:0]         lost_inc;
  logic                               stop;
  logic [lfc_pkg::FLIP_W:0]           srch_inc;

  always_comb begin
    lon  = left_sample > cfg.line_threshold;
    ron  = right_sample > cfg.line_threshold;
    diff = $signed({1'b0, left_sample}) - $signed({1'b0, right_sample});
    mag  = diff[lfc_pkg::SAMPLE_W] ? lfc_pkg::SAMPLE_W'(-diff)
                                   : diff[lfc_pkg::SAMPLE_W-1:0];
    // Q8 gain, round half away from zero on the magnitude
    prod = mag * cfg.steer_gain;
    rnd  = {1'b0, prod} + (PW+1)'(128);
    tmag = rnd[PW:8];
    turn = diff[lfc_pkg::SAMPLE_W] ? -$signed(W'(tmag)) : $signed(W'(tmag));

    base_w = $signed({{PADS{1'b0}}, cfg.cruise_speed});
    trn_w  = $signed({{PADS{1'b0}}, cfg.swerve_speed});

    lost_inc = (track.lost_ticks < cfg.lost_timeout) ? track.lost_ticks + 1'b1
                                                      : track.lost_ticks;
    stop     = lost_inc >= cfg.lost_timeout;
    srch_inc = {1'b0, track.search_ticks} + 1'b1;

    track_next = track;
    lv   = base_w;
    rv   = base_w;
    mode = lfc_pkg::MODE_BOTH;

    if (!lon && !ron) begin
      track_next.lost_ticks = lost_inc;
      if (stop) begin
        lv   = '0;
        rv   = '0;
        mode = lfc_pkg::MODE_STOP;
      end else begin
        lv   = track.spin_left ? -trn_w : trn_w;
        rv   = track.spin_left ? trn_w : -trn_w;
        mode = lfc_pkg::MODE_SEARCH;
        if (srch_inc > {1'b0, cfg.search_flip}) begin
          track_next.spin_left    = !track.spin_left;
          track_next.search_ticks = '0;
        end else begin
          track_next.search_ticks = srch_inc[lfc_pkg::FLIP_W-1:0];
        end
      end
    end else begin
      track_next.lost_ticks = '0;
      if (lon && ron) begin
        if (mag > cfg.diff_deadband) begin
          lv = base_w - turn;
          rv = base_w + turn;
        end
        mode = lfc_pkg::MODE_BOTH;
      end else if (lon) begin
        lv   = base_w + trn_w;
        rv   = base_w - trn_w;
        mode = lfc_pkg::MODE_LEFT;
      end else begin
        lv   = base_w - trn_w;
        rv   = base_w + trn_w;
        mode = lfc_pkg::MODE_RIGHT;
      end
    end

    left_speed  = clamp(lv, cfg.speed_limit);
    right_speed = clamp(rv, cfg.speed_limit);
  end

endmodule

[verif/tb_two_sensor_line_follower_control.sv]
module tb_two_sensor_line_follower_control;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OUT_W      = lfc_pkg::OUT_W;
  localparam int SAMPLE_W   = lfc_pkg::SAMPLE_W;
  localparam int WIDE_W     = lfc_pkg::WIDE_W;
  localparam int SPEED_W    = lfc_pkg::SPEED_W;
  localparam int FLIP_W     = lfc_pkg::FLIP_W;
  localparam int CFG_IDX_W  = lfc_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = lfc_pkg::CFG_DATA_W;

  // result word as the wheels should see it
  typedef struct packed {
    logic signed [OUT_W-1:0] left;
    logic signed [OUT_W-1:0] right;
    lfc_pkg::mode_t          mode;
  } wheel_cmd_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] ls;
    logic [SAMPLE_W-1:0] rs;
  } sample_pair_t;

  localparam int PIPE_LAT       = 2;     // accept edge to earliest result handshake
  localparam int LONG_HOLD      = 400;   // receiver hold-off, cycles
  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no word moving on any channel
  localparam int RAND_PHASES    = 10;
  localparam int RAND_PER_PHASE = 150;

  logic clk;
  logic rst;

  lfc_in_if  samples ();
  lfc_out_if speeds ();
  lfc_cfg_if cfg ();

  two_sensor_line_follower_control dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .speeds  (speeds),
    .cfg     (cfg)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: its own copy of the registers and of the tracking state.
  // Only the checking process below touches these, except that the stimulus
  // code reads the registers while the block sits idle.
  // ---------------------------------------------------------------------------
  lfc_pkg::cfg_t   ctl_regs;
  lfc_pkg::track_t line_trk;

  sample_pair_t pend_q[$];      // sample words waiting to be driven
  wheel_cmd_t   wheel_q[$];     // expected result words, oldest first

  int          fail_cnt;
  int          words_in;
  int          results_seen;
  int          cfg_writes;
  int          setups;
  int          mode_hits[5];
  logic        in_taken;        // sample word accepted at the last rising edge
  int unsigned src_gap;
  int unsigned snk_gap;
  int unsigned hold_cnt;
  int          hold_asks;
  int          hold_seen;
  logic        src_quiet;       // no sender gaps in this phase
  logic        snk_quiet;       // no receiver gaps in this phase
  int          stall_cycles;

  // Gap length: mostly back to back, sometimes short, rarely long.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Symmetric clamp to +-speed_limit, then cut to the output width.
  function automatic logic signed [OUT_W-1:0] clamp_wheel(
    input logic signed [WIDE_W-1:0] v
  );
    logic signed [WIDE_W-1:0] lim;
    lim = {{(WIDE_W-SPEED_W){1'b0}}, ctl_regs.speed_limit};
    if (v > lim) v = lim;
    else if (v < -lim) v = -lim;
    return v[OUT_W-1:0];
  endfunction

  // One control tick: updates the tracking state, returns the wheel command.
  function automatic wheel_cmd_t steer_step(input logic [SAMPLE_W-1:0] ls,
                                            input logic [SAMPLE_W-1:0] rs);
    wheel_cmd_t                cmd;
    logic                      lon;
    logic                      ron;
    logic signed [SAMPLE_W+1:0] diff;
    logic [SAMPLE_W:0]         mag;
    logic [2*SAMPLE_W+1:0]     prod;
    logic signed [WIDE_W-1:0]  base;
    logic signed [WIDE_W-1:0]  trn;
    logic signed [WIDE_W-1:0]  turn;
    logic signed [WIDE_W-1:0]  lv;
    logic signed [WIDE_W-1:0]  rv;
    logic [FLIP_W:0]           nxt;
    lon  = ls > ctl_regs.line_threshold;   // strictly above means on the line
    ron  = rs > ctl_regs.line_threshold;
    base = {{(WIDE_W-SPEED_W){1'b0}}, ctl_regs.cruise_speed};
    trn  = {{(WIDE_W-SPEED_W){1'b0}}, ctl_regs.swerve_speed};

    // lost counter saturates at the timeout; at or past it the robot stops
    // and the search state is left alone
    if (!lon && !ron) begin
      if (line_trk.lost_ticks < ctl_regs.lost_timeout)
        line_trk.lost_ticks = line_trk.lost_ticks + 1'b1;
      if (line_trk.lost_ticks >= ctl_regs.lost_timeout) begin
        cmd.left  = '0;
        cmd.right = '0;
        cmd.mode  = lfc_pkg::MODE_STOP;
        return cmd;
      end
    end else begin
      line_trk.lost_ticks = '0;
    end

    if (lon && ron) begin
      diff = $signed({2'b00, ls}) - $signed({2'b00, rs});
      mag  = (diff < 0) ? (SAMPLE_W+1)'(-diff) : (SAMPLE_W+1)'(diff);
      lv   = base;
      rv   = base;
      if (mag > ctl_regs.diff_deadband) begin
        // Q8 gain, round half away from zero on the magnitude
        prod = mag * ctl_regs.steer_gain + 34'd128;
        turn = {2'b00, prod[2*SAMPLE_W+1:8]};
        if (diff < 0) turn = -turn;
        lv = base - turn;
        rv = base + turn;
      end
      cmd.mode = lfc_pkg::MODE_BOTH;
    end else if (lon) begin
      lv       = base + trn;
      rv       = base - trn;
      cmd.mode = lfc_pkg::MODE_LEFT;
    end else if (ron) begin
      lv       = base - trn;
      rv       = base + trn;
      cmd.mode = lfc_pkg::MODE_RIGHT;
    end else begin
      // spin in place; direction flips once the count passes search_flip
      lv = line_trk.spin_left ? -trn : trn;
      rv = line_trk.spin_left ? trn : -trn;
      nxt = {1'b0, line_trk.search_ticks} + 1'b1;
      if (nxt > {1'b0, ctl_regs.search_flip}) begin
        line_trk.spin_left    = ~line_trk.spin_left;
        line_trk.search_ticks = '0;
      end else begin
        line_trk.search_ticks = nxt[FLIP_W-1:0];
      end
      cmd.mode = lfc_pkg::MODE_SEARCH;
    end
    cmd.left  = clamp_wheel(lv);
    cmd.right = clamp_wheel(rv);
    return cmd;
  endfunction

  function automatic void load_reg(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] val);
    case (lfc_pkg::reg_idx_t'(idx))
      lfc_pkg::REG_LINE_THRESHOLD: ctl_regs.line_threshold = val;
      lfc_pkg::REG_BASE_SPEED:     ctl_regs.cruise_speed   = val[SPEED_W-1:0];
      lfc_pkg::REG_TURN_SPEED:     ctl_regs.swerve_speed   = val[SPEED_W-1:0];
      lfc_pkg::REG_MAX_SPEED:      ctl_regs.speed_limit    = val[SPEED_W-1:0];
      lfc_pkg::REG_LOST_TIMEOUT:   ctl_regs.lost_timeout   = val;
      lfc_pkg::REG_DIFF_DEADBAND:  ctl_regs.diff_deadband  = val;
      lfc_pkg::REG_STEER_GAIN:     ctl_regs.steer_gain     = val;
      lfc_pkg::REG_SEARCH_FLIP:    ctl_regs.search_flip    = val[FLIP_W-1:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Checking: everything is sampled at the rising edge. Config writes and
  // accepted sample words feed the predictor, result words are compared.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_speeds
    wheel_cmd_t want;
    if (rst) begin
      ctl_regs.line_threshold = lfc_pkg::RST_LINE_THRESHOLD;
      ctl_regs.cruise_speed   = lfc_pkg::RST_BASE_SPEED;
      ctl_regs.swerve_speed   = lfc_pkg::RST_TURN_SPEED;
      ctl_regs.speed_limit    = lfc_pkg::RST_MAX_SPEED;
      ctl_regs.lost_timeout   = lfc_pkg::RST_LOST_TIMEOUT;
      ctl_regs.diff_deadband  = lfc_pkg::RST_DIFF_DEADBAND;
      ctl_regs.steer_gain     = lfc_pkg::RST_STEER_GAIN;
      ctl_regs.search_flip    = lfc_pkg::RST_SEARCH_FLIP;
      line_trk = lfc_pkg::RST_TRACK;
      wheel_q.delete();
      in_taken <= 1'b0;
    end else begin
      in_taken <= samples.valid && samples.ready;
      if (cfg.valid && cfg.ready) begin
        load_reg(cfg.index, cfg.data);
        cfg_writes++;
      end
      if (samples.valid && samples.ready) begin
        wheel_q.push_back(steer_step(samples.left_sample, samples.right_sample));
        words_in++;
      end
      if (speeds.valid && speeds.ready) begin
        results_seen++;
        if (wheel_q.size() == 0) begin
          $error("result word with nothing expected: left_speed %0d right_speed %0d mode %0d",
                 speeds.left_speed, speeds.right_speed, speeds.drive_mode);
          fail_cnt++;
        end else begin
          want = wheel_q.pop_front();
          mode_hits[want.mode]++;
          if (speeds.left_speed !== want.left) begin
            $error("left_speed: expected %0d, got %0d", want.left, speeds.left_speed);
            fail_cnt++;
          end
          if (speeds.right_speed !== want.right) begin
            $error("right_speed: expected %0d, got %0d", want.right, speeds.right_speed);
            fail_cnt++;
          end
          if (speeds.drive_mode !== want.mode) begin
            $error("drive_mode: expected %0d, got %0d", want.mode, speeds.drive_mode);
            fail_cnt++;
          end
        end
      end
    end
  end

  // Watchdog: any word moving on any channel restarts the count.
  always @(posedge clk) begin
    if (rst || (samples.valid && samples.ready) || (speeds.valid && speeds.ready) ||
        (cfg.valid && cfg.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("two_sensor_line_follower_control: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sample driver: inputs change on the falling edge. A word stays up until
  // the edge that takes it; the gap after it is drawn when it goes up.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_samples
    sample_pair_t w;
    if (rst) begin
      samples.valid <= 1'b0;
      src_gap       <= 0;
    end else if (samples.valid && !in_taken) begin
      // still waiting for ready
    end else if (src_gap != 0) begin
      samples.valid <= 1'b0;
      src_gap       <= src_gap - 1;
    end else if (pend_q.size() != 0) begin
      w = pend_q.pop_front();
      samples.valid        <= 1'b1;
      samples.left_sample  <= w.ls;
      samples.right_sample <= w.rs;
      if (!src_quiet) src_gap <= idle_len();
    end else begin
      samples.valid <= 1'b0;
    end
  end

  // Long receiver hold-off, started on request and counted down here.
  always @(negedge clk) begin
    if (rst) begin
      hold_cnt  <= 0;
      hold_seen <= 0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (hold_asks != hold_seen) begin
      hold_cnt  <= LONG_HOLD;
      hold_seen <= hold_seen + 1;
    end
  end

  // Receiver ready with random stalls.
  always @(negedge clk) begin
    if (rst) begin
      speeds.ready <= 1'b0;
      snk_gap      <= 0;
    end else if (hold_cnt != 0) begin
      speeds.ready <= 1'b0;
    end else if (snk_gap != 0) begin
      speeds.ready <= 1'b0;
      snk_gap      <= snk_gap - 1;
    end else begin
      speeds.ready <= 1'b1;
      if (!snk_quiet) snk_gap <= idle_len();
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_pair(input int l, input int r);
    sample_pair_t w;
    w.ls = l[SAMPLE_W-1:0];
    w.rs = r[SAMPLE_W-1:0];
    pend_q.push_back(w);
  endtask

  // Wait for the pipe to empty: nothing queued, nothing offered, nothing owed.
  task automatic settle_pipe();
    do @(posedge clk);
    while (pend_q.size() != 0 || samples.valid || wheel_q.size() != 0);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  // One config word; valid stays up across back to back writes.
  task automatic write_reg(input lfc_pkg::reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk);
    while (!cfg.ready);
  endtask

  task automatic cfg_done();
    @(negedge clk);
    cfg.valid <= 1'b0;
    setups++;
  endtask

  // Register value: an extreme now and then, else something a real robot would use.
  function automatic logic [CFG_DATA_W-1:0] pick_reg(input lfc_pkg::reg_idx_t idx);
    int unsigned r;
    r = $urandom_range(0, 9);
    case (idx)
      lfc_pkg::REG_LINE_THRESHOLD:
        return (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom_range(0, 2000));
      lfc_pkg::REG_BASE_SPEED:
        return (r == 0) ? 16'd0 : (r == 1) ? 16'h0FFF : 16'($urandom_range(0, 2000));
      lfc_pkg::REG_TURN_SPEED:
        return (r == 0) ? 16'd0 : (r == 1) ? 16'h0FFF : 16'($urandom_range(0, 1500));
      lfc_pkg::REG_MAX_SPEED:
        return (r == 0) ? 16'd0 : (r == 1) ? 16'h0FFF : 16'($urandom_range(200, 4095));
      lfc_pkg::REG_LOST_TIMEOUT:
        return (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom_range(1, 40));
      lfc_pkg::REG_DIFF_DEADBAND:
        return (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom_range(0, 64));
      lfc_pkg::REG_STEER_GAIN:
        return (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom_range(0, 3000));
      default:
        return (r == 0) ? 16'd0 : (r == 1) ? 16'h00FF : 16'($urandom_range(0, 12));
    endcase
  endfunction

  // Sample on the line for the current threshold (none exists at full scale).
  function automatic int on_val();
    int t;
    t = ctl_regs.line_threshold;
    if (t >= 65535) return 65535;
    return t + 1 + $urandom_range(0, (65534 - t) < 400 ? 65534 - t : 400);
  endfunction

  function automatic int off_val();
    return $urandom_range(0, ctl_regs.line_threshold);
  endfunction

  // Mostly well-formed tracking: both on near each other, one-sided
  // corrections, runs off the line long enough to reach the timeout,
  // and some raw noise over the full sample range.
  task automatic fill_random(input int n);
    int k;
    int a;
    int b;
    int t;
    int len;
    int unsigned r;
    k = 0;
    t = ctl_regs.line_threshold;
    while (k < n) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        a = on_val();
        len = $urandom_range(0, 2 * ctl_regs.diff_deadband + 16);
        b = $urandom_range(0, 1) ? a + len : a - len;
        if (b > 65535) b = 65535;
        if (b <= t && t < 65535) b = t + 1;
        push_pair(a, b);
        k++;
      end else if (r < 50) begin
        push_pair(on_val(), off_val());
        k++;
      end else if (r < 65) begin
        push_pair(off_val(), on_val());
        k++;
      end else if (r < 88) begin
        len = ctl_regs.lost_timeout + 6;
        len = $urandom_range(1, len > 80 ? 80 : len);
        if (len > n - k) len = n - k;
        repeat (len) push_pair(off_val(), off_val());
        k += len;
      end else begin
        push_pair($urandom_range(0, 65535), $urandom_range(0, 65535));
        k++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : run_test
    int p;
    int i;
    rst          = 1'b1;
    samples.valid        = 1'b0;
    samples.left_sample  = '0;
    samples.right_sample = '0;
    speeds.ready = 1'b0;
    cfg.valid    = 1'b0;
    cfg.index    = lfc_pkg::REG_LINE_THRESHOLD;
    cfg.data     = '0;
    fail_cnt     = 0;
    words_in     = 0;
    results_seen = 0;
    cfg_writes   = 0;
    setups       = 0;
    hold_asks    = 0;
    src_quiet    = 1'b0;
    snk_quiet    = 1'b0;
    foreach (mode_hits[m]) mode_hits[m] = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // --- directed, reset defaults ---
    push_pair(16'hFFFF, 16'hFFFF);   // both on, no difference
    push_pair(16'hFFFF, 113);        // huge positive difference, clamps
    push_pair(113, 16'hFFFF);        // huge negative difference
    push_pair(200, 190);             // just past the deadband
    push_pair(200, 192);             // on the deadband edge: no steering
    push_pair(200, 208);             // negative edge of the deadband
    push_pair(113, 112);             // left only, right exactly at threshold
    push_pair(112, 113);             // right only
    push_pair(16'hFFFF, 0);
    push_pair(0, 0);                 // first search tick, spin left
    push_pair(112, 112);             // at threshold counts as off
    settle_pipe();

    // short timeout, fast flip: the lost count carried over stops at once, then the line comes back
    write_reg(lfc_pkg::REG_LOST_TIMEOUT, 16'd3);
    write_reg(lfc_pkg::REG_SEARCH_FLIP, 16'd1);
    cfg_done();
    repeat (4) push_pair(0, 0);
    push_pair(500, 0);
    settle_pipe();

    // zero timeout stops at once, zero flip, zero clamp forces all speeds to 0
    write_reg(lfc_pkg::REG_LOST_TIMEOUT, 16'd0);
    write_reg(lfc_pkg::REG_SEARCH_FLIP, 16'd0);
    write_reg(lfc_pkg::REG_MAX_SPEED, 16'd0);
    cfg_done();
    push_pair(0, 0);
    push_pair(16'hFFFF, 16'hFFFF);
    push_pair(16'hFFFF, 0);
    settle_pipe();

    // most other registers at an extreme, lost timeout at 10
    write_reg(lfc_pkg::REG_LINE_THRESHOLD, 16'd0);
    write_reg(lfc_pkg::REG_BASE_SPEED, 16'h0FFF);
    write_reg(lfc_pkg::REG_TURN_SPEED, 16'h0FFF);
    write_reg(lfc_pkg::REG_MAX_SPEED, 16'h0FFF);
    write_reg(lfc_pkg::REG_LOST_TIMEOUT, 16'd10);
    write_reg(lfc_pkg::REG_DIFF_DEADBAND, 16'd0);
    write_reg(lfc_pkg::REG_STEER_GAIN, 16'hFFFF);
    cfg_done();
    push_pair(0, 0);                 // flip on every search tick
    push_pair(0, 0);
    push_pair(1, 0);
    push_pair(16'hFFFF, 1);
    push_pair(1, 16'hFFFF);
    settle_pipe();

    // --- long search: full flip count before the timeout hits ---
    write_reg(lfc_pkg::REG_LINE_THRESHOLD, 16'd112);
    write_reg(lfc_pkg::REG_MAX_SPEED, 16'd1608);
    write_reg(lfc_pkg::REG_LOST_TIMEOUT, 16'd300);
    write_reg(lfc_pkg::REG_SEARCH_FLIP, 16'hFF);
    cfg_done();
    for (i = 0; i < 320; i++) push_pair(off_val(), off_val());
    push_pair(on_val(), on_val());
    settle_pipe();

    // --- random phases, each with its own register set ---
    for (p = 0; p < RAND_PHASES; p++) begin
      for (i = 0; i < 8; i++)
        write_reg(lfc_pkg::reg_idx_t'(i), pick_reg(lfc_pkg::reg_idx_t'(i)));
      cfg_done();
      src_quiet = ($urandom_range(0, 3) == 0);
      snk_quiet = ($urandom_range(0, 3) == 0);
      fill_random(RAND_PER_PHASE / 2);
      // first phase: receiver holds off while the sender keeps offering
      if (p == 0) begin
        src_quiet = 1'b1;
        hold_asks++;
      end
      // sender pause: let every result drain before the second half
      settle_pipe();
      fill_random(RAND_PER_PHASE / 2);
      settle_pipe();
    end

    $display("covered %0d sample words over %0d register setups, %0d result words checked",
             words_in, setups, results_seen);
    $display("modes: both %0d, left %0d, right %0d, search %0d, stop %0d",
             mode_hits[lfc_pkg::MODE_BOTH], mode_hits[lfc_pkg::MODE_LEFT],
             mode_hits[lfc_pkg::MODE_RIGHT], mode_hits[lfc_pkg::MODE_SEARCH],
             mode_hits[lfc_pkg::MODE_STOP]);
    if (fail_cnt == 0 && wheel_q.size() == 0) begin
      $display("two_sensor_line_follower_control: match");
    end else begin
      if (wheel_q.size() != 0)
        $error("%0d expected result words never arrived", wheel_q.size());
      $display("two_sensor_line_follower_control: mismatch");
    end
    $finish;
  end

endmodule
